@@ hdl/drse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package drse_pkg;

    // sample and code widths
    localparam int SAMPLE_W = 8;
    localparam int CODE_W   = 10;
    localparam int LEN_W    = 4;
    localparam int RUN_W    = 4;

    // longest run sent as one word
    localparam int MAX_RUN  = 8;

    // largest delta magnitude sent in the short form
    localparam int SHORT_MAG_MAX = 30;

    // words one sample can cause
    localparam int WORDS_PER_ITEM = 3;
    localparam int CNT_W          = $clog2(WORDS_PER_ITEM + 1);

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one code word
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              eos;
    } t_word;

    // all words of one sample, oldest in slot 0
    typedef struct packed {
        logic [CNT_W-1:0]                 cnt;
        t_word [WORDS_PER_ITEM-1:0]       words;
    } t_entry;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

@@ hdl/delta_rle_sample_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// delta and run-length coder for signed 8-bit samples. a sample is taken on
// every edge where push is high and full is low, so the block can take one
// sample per cycle. each sample yields zero to three code words (right-aligned
// in o_code_bits, first bit sent is the top used bit, o_code_len bits valid);
// words leave one per cycle through empty/pop, the oldest first, and
// o_last_for_item marks the final word of each sample. a sample is classified
// and its words laid out in the cycle it is taken by the front, stored as one
// entry in a four-entry queue at that edge, and unpacked by the back into the
// output register once it heads the queue and the register is free or being
// popped. the back moves one word per cycle while pop is high, so the
// sustained rate is set by the words per sample: one sample per cycle when
// samples average at most one word (zero-delta samples inside a run cost
// nothing), with run flushes and end codes soaking into the queue; full
// rises only once the queue holds four waiting samples.

module delta_rle_sample_encoder
    import drse_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input transaction
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_final_sample,
    // result transaction
    output logic                            empty,
    input  wire logic                       pop,
    output logic [CODE_W-1:0]               o_code_bits,
    output logic [LEN_W-1:0]                o_code_len,
    output logic                            o_end_of_stream,
    output logic                            o_last_for_item
);

    t_entry    front_entry;
    t_entry    head_entry;
    t_q_status q_status;
    logic      front_accept;
    logic      q_rd;

    // front: delta, run tracking and word layout per sample
    drse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_sample       (i_sample),
        .i_final_sample (i_final_sample),
        .i_q_status     (q_status),
        .o_accept       (front_accept),
        .o_entry        (front_entry)
    );

    // queue of per-sample word groups, decouples the two sides
    drse_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_accept),
        .i_wr_entry (front_entry),
        .i_rd       (q_rd),
        .o_rd_entry (head_entry),
        .o_status   (q_status)
    );

    // back: one word per cycle into the output register, stalled while a waiting word is not popped
    drse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_entry),
        .i_q_status      (q_status),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_code_bits     (o_code_bits),
        .o_code_len      (o_code_len),
        .o_end_of_stream (o_end_of_stream),
        .o_last_for_item (o_last_for_item)
    );

    // the front holds off while the queue has no free entry
    assign full = q_status.full;

endmodule

`default_nettype wire

@@ hdl/drse_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drse_front
    import drse_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [SAMPLE_W-1:0]  i_sample,
    input  wire logic                 i_final_sample,
    input  wire t_q_status            i_q_status,
    output logic                      o_accept,
    output t_entry                    o_entry
);

    logic [SAMPLE_W-1:0] r_prev;
    logic [RUN_W-1:0]    r_run;
    logic                r_first;

    logic [RUN_W-1:0]    n_run;

    // run word: 01 then count - 1
    function automatic t_word run_word(input logic [RUN_W-1:0] count);
        t_word w;
        logic [RUN_W-1:0] cm1;
        cm1    = count - RUN_W'(1);
        w.bits = {5'b00000, 2'b01, cm1[2:0]};
        w.len  = LEN_W'(5);
        w.eos  = 1'b0;
        return w;
    endfunction

    // short delta word: 00, length code, magnitude + 1 (inverted when negative)
    function automatic t_word delta_word(input logic [SAMPLE_W-1:0] mag, input logic neg);
        t_word w;
        logic [4:0] v;
        logic [4:0] vv;
        v    = mag[4:0] + 5'd1;
        vv   = neg ? ~v : v;
        w.eos = 1'b0;
        if (v[4]) begin
            w.bits = {3'b000, 2'b11, vv[4:0]};
            w.len  = LEN_W'(9);
        end else if (v[3]) begin
            w.bits = {4'b0000, 2'b10, vv[3:0]};
            w.len  = LEN_W'(8);
        end else if (v[2]) begin
            w.bits = {5'b00000, 2'b01, vv[2:0]};
            w.len  = LEN_W'(7);
        end else begin
            w.bits = {6'b000000, 2'b00, vv[1:0]};
            w.len  = LEN_W'(6);
        end
        return w;
    endfunction

    assign o_accept = i_push && !i_q_status.full;

    // classify the sample and lay out its words
    always_comb begin
        logic [SAMPLE_W-1:0] du;
        logic [SAMPLE_W-1:0] mag;
        logic                neg;
        logic [RUN_W-1:0]    rl_inc;
        logic [CNT_W-1:0]    k;
        du      = i_sample - r_prev;
        neg     = du[SAMPLE_W-1];
        mag     = neg ? (SAMPLE_W'(0) - du) : du;
        rl_inc  = r_run + RUN_W'(1);
        k       = '0;
        n_run   = r_run;
        o_entry = '0;

        if (r_first) begin
            o_entry.words[k] = '{bits: {2'b00, i_sample}, len: LEN_W'(8), eos: 1'b0};
            k                = k + CNT_W'(1);
            n_run            = '0;
        end else if (du == '0) begin
            if (rl_inc >= RUN_W'(MAX_RUN)) begin
                o_entry.words[k] = run_word(rl_inc);
                k                = k + CNT_W'(1);
                n_run            = '0;
            end else begin
                n_run = rl_inc;
            end
        end else begin
            // a non-zero delta breaks any open run
            if (r_run != '0) begin
                o_entry.words[k] = run_word(r_run);
                k                = k + CNT_W'(1);
            end
            n_run = '0;
            if (mag <= SAMPLE_W'(SHORT_MAG_MAX)) begin
                o_entry.words[k] = delta_word(mag, neg);
            end else begin
                o_entry.words[k] = '{bits: {2'b10, i_sample}, len: LEN_W'(10), eos: 1'b0};
            end
            k = k + CNT_W'(1);
        end

        if (i_final_sample) begin
            if (n_run != '0) begin
                o_entry.words[k] = run_word(n_run);
                k                = k + CNT_W'(1);
            end
            o_entry.words[k] = '{bits: CODE_W'(3), len: LEN_W'(2), eos: 1'b1};
            k                = k + CNT_W'(1);
        end

        o_entry.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_run   <= '0;
            r_first <= 1'b1;
        end else if (o_accept) begin
            if (i_final_sample) begin
                r_prev  <= '0;
                r_run   <= '0;
                r_first <= 1'b1;
            end else begin
                r_prev  <= i_sample;
                r_run   <= n_run;
                r_first <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/drse_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drse_queue
    import drse_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_entry i_wr_entry,
    input  wire logic   i_rd,
    output t_entry      o_rd_entry,
    output t_q_status   o_status
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic do_wr;
    logic do_rd;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);

    // entries with no words are never stored
    assign do_wr = i_wr && !o_status.full && (i_wr_entry.cnt != '0);
    assign do_rd = i_rd && !o_status.empty;

    assign o_rd_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/drse_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drse_back
    import drse_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_entry        i_head,
    input  wire t_q_status     i_q_status,
    output logic               o_q_rd,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [CODE_W-1:0]  o_code_bits,
    output logic [LEN_W-1:0]   o_code_len,
    output logic               o_end_of_stream,
    output logic               o_last_for_item
);

    logic                r_valid;
    t_word               r_word;
    logic                r_last;
    logic [CNT_W-1:0]    r_idx;

    logic                take;
    logic                load;
    logic                head_last;
    t_word               head_word;

    assign take = i_pop && r_valid;
    assign load = !i_q_status.empty && (!r_valid || take);

    always_comb begin
        case (r_idx)
            CNT_W'(0): head_word = i_head.words[0];
            CNT_W'(1): head_word = i_head.words[1];
            default:   head_word = i_head.words[2];
        endcase
    end

    assign head_last = (r_idx == (i_head.cnt - CNT_W'(1)));
    assign o_q_rd    = load && head_last;

    // output word register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= head_word;
            r_last <= head_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= head_last ? '0 : (r_idx + CNT_W'(1));
            end else if (take) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty         = !r_valid;
    assign o_code_bits     = r_word.bits;
    assign o_code_len      = r_word.len;
    assign o_end_of_stream = r_word.eos;
    assign o_last_for_item = r_last;

endmodule

`default_nettype wire

@@ hdl/drse_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drse_checker
    import drse_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       push,
    input wire logic                       full,
    input wire logic signed [SAMPLE_W-1:0] i_sample,
    input wire logic                       i_final_sample,
    input wire logic                       empty,
    input wire logic                       pop,
    input wire logic [CODE_W-1:0]          o_code_bits,
    input wire logic [LEN_W-1:0]           o_code_len,
    input wire logic                       o_end_of_stream,
    input wire logic                       o_last_for_item
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // end code closes the sample's words
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_stream) |-> o_last_for_item)
        else $error("end code not last word of its sample");

    a_eos_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_stream) |-> (o_code_len == LEN_W'(2) &&
                                          o_code_bits == CODE_W'(3)))
        else $error("end code malformed");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_code_len == LEN_W'(2) || o_code_len == LEN_W'(5) ||
                    o_code_len == LEN_W'(6) || o_code_len == LEN_W'(7) ||
                    o_code_len == LEN_W'(8) || o_code_len == LEN_W'(9) ||
                    o_code_len == LEN_W'(10)))
        else $error("illegal code length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_code_bits) && $stable(o_code_len)))
        else $error("waiting result changed");

endmodule

bind delta_rle_sample_encoder drse_checker u_drse_checker (.*);

`default_nettype wire

@@ tb/delta_rle_sample_encoder_test.sv @@
`timescale 1ns / 1ps

module delta_rle_sample_encoder_test;
    import drse_pkg::*;

    // stimulus shaping
    localparam int RANDOM_ITEMS = 160;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 8;

    // one expected code word as it should leave the block
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              eos;
        logic              last;
    } t_code;

    // how the next random sample relates to the one before it
    typedef enum int {
        KIND_REPEAT,
        KIND_SMALL,
        KIND_JUMP,
        KIND_NOISE
    } t_sample_kind;

    // clock, reset and block inputs, all known from time zero
    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       push           = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample       = '0;
    logic                       i_final_sample = 1'b0;
    logic                       pop            = 1'b0;

    logic                       full;
    logic                       empty;
    logic [CODE_W-1:0]          o_code_bits;
    logic [LEN_W-1:0]           o_code_len;
    logic                       o_end_of_stream;
    logic                       o_last_for_item;

    // words still owed by the block, oldest at the front
    t_code code_words_due[$];
    int    error_count = 0;

    // encoder state as the testbench sees it
    logic [SAMPLE_W-1:0] prev_sample_m = '0;
    logic [RUN_W-1:0]    run_count_m   = '0;
    bit                  block_start_m = 1'b1;

    // sender burst control
    bit sender_idles = 1'b1;
    int burst_left   = 0;

    delta_rle_sample_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .i_final_sample  (i_final_sample),
        .empty           (empty),
        .pop             (pop),
        .o_code_bits     (o_code_bits),
        .o_code_len      (o_code_len),
        .o_end_of_stream (o_end_of_stream),
        .o_last_for_item (o_last_for_item)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // run word: 01 then the count minus one in three bits
    function automatic t_code run_word(input logic [RUN_W-1:0] count);
        t_code w;
        w      = '0;
        w.bits = CODE_W'({2'b01, 3'(count - 1'b1)});
        w.len  = LEN_W'(5);
        return w;
    endfunction

    // works out the words one accepted sample causes and queues them
    function automatic void encode_sample(input logic [SAMPLE_W-1:0] s, input bit fin);
        t_code         words[WORDS_PER_ITEM];
        int            k;
        logic [7:0]    du;
        bit            neg;
        int unsigned   mag;
        int unsigned   v;
        int unsigned   n;
        k = 0;
        if (block_start_m) begin
            // opening sample of a block goes out raw
            words[k]      = '0;
            words[k].bits = CODE_W'(s);
            words[k].len  = LEN_W'(8);
            k++;
            block_start_m = 1'b0;
            run_count_m   = '0;
        end else begin
            du = s - prev_sample_m;
            if (du == 8'd0) begin
                run_count_m = run_count_m + 1'b1;
                if (run_count_m >= RUN_W'(MAX_RUN)) begin
                    words[k] = run_word(run_count_m);
                    k++;
                    run_count_m = '0;
                end
            end else begin
                neg = du[7];
                mag = neg ? (256 - du) : du;
                // a pending run is flushed ahead of the delta word
                if (run_count_m != '0) begin
                    words[k] = run_word(run_count_m);
                    k++;
                    run_count_m = '0;
                end
                words[k] = '0;
                if (mag <= SHORT_MAG_MAX) begin
                    v = mag + 1;
                    n = $clog2(v + 1);
                    if (neg) begin
                        v = ~v & ((1 << n) - 1);
                    end
                    words[k].bits = CODE_W'(((n - 2) << n) | v);
                    words[k].len  = LEN_W'(4 + n);
                end else begin
                    words[k].bits = CODE_W'({2'b10, s});
                    words[k].len  = LEN_W'(10);
                end
                k++;
            end
        end
        prev_sample_m = s;
        if (fin) begin
            if (run_count_m != '0) begin
                words[k] = run_word(run_count_m);
                k++;
            end
            words[k]      = '0;
            words[k].bits = CODE_W'(3);
            words[k].len  = LEN_W'(2);
            words[k].eos  = 1'b1;
            k++;
            prev_sample_m = '0;
            run_count_m   = '0;
            block_start_m = 1'b1;
        end
        for (int i = 0; i < k; i++) begin
            words[i].last = (i == k - 1);
            code_words_due.push_back(words[i]);
        end
    endfunction

    // one input transaction, then a gap when the sender idles and the current burst runs out
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit fin);
        int gap;
        push           <= 1'b1;
        i_sample       <= s;
        i_final_sample <= fin;
        do begin
            @(posedge i_clk);
        end while (full);
        encode_sample(s, fin);
        if (sender_idles) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 5);
                burst_left = $urandom_range(1, 10);
                push           <= 1'b0;
                i_sample       <= SAMPLE_W'($urandom);
                i_final_sample <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // blocks of one sample: raw word then end code, at both sample extremes
    task automatic test_single_sample_blocks();
        send_sample(8'h80, 1'b1);
        send_sample(8'h7f, 1'b1);
    endtask

    // short-form edges at plus and minus 30, raw form just past them, and the
    // delta of -128 that wraps and must go out raw
    task automatic test_delta_forms();
        send_sample(8'd0, 1'b0);
        send_sample(8'd30, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd31, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd127, 1'b0);
        send_sample(8'hff, 1'b0);
        send_sample(8'h80, 1'b1);
    endtask

    // a run broken by a delta, a run hitting its limit, and a final sample
    // closing a run of one
    task automatic test_runs();
        send_sample(8'd5, 1'b0);
        send_sample(8'd5, 1'b0);
        send_sample(8'd5, 1'b0);
        send_sample(8'd6, 1'b0);
        repeat (MAX_RUN) send_sample(8'd6, 1'b0);
        send_sample(8'd6, 1'b1);
    endtask

    // mostly well-formed blocks with runs, small and large deltas, closed by
    // a final sample; now and then a noise block with finals anywhere
    task automatic test_random_blocks();
        int           items;
        int           blk_len;
        int           j;
        int           repeats_left;
        int           mag;
        bit           noisy;
        bit           fin;
        t_sample_kind kind;
        logic [SAMPLE_W-1:0] cur;
        items = 0;
        while (items < RANDOM_ITEMS) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            noisy        = ($urandom_range(0, 7) == 0);
            blk_len      = $urandom_range(1, 24);
            repeats_left = 0;
            cur          = SAMPLE_W'($urandom);
            for (j = 0; j < blk_len; j++) begin
                if (j != 0) begin
                    if (repeats_left > 0) begin
                        kind = KIND_REPEAT;
                        repeats_left--;
                    end else if (noisy) begin
                        kind = KIND_NOISE;
                    end else begin
                        kind = t_sample_kind'($urandom_range(0, 3));
                        if (kind == KIND_REPEAT) begin
                            repeats_left = $urandom_range(0, 11);
                        end
                    end
                    case (kind)
                        KIND_REPEAT: begin
                        end
                        KIND_SMALL: begin
                            mag = $urandom_range(1, SHORT_MAG_MAX + 1);
                            cur = $urandom_range(0, 1) ? cur - SAMPLE_W'(mag)
                                                       : cur + SAMPLE_W'(mag);
                        end
                        KIND_JUMP: begin
                            mag = $urandom_range(SHORT_MAG_MAX + 1, 128);
                            cur = $urandom_range(0, 1) ? cur - SAMPLE_W'(mag)
                                                       : cur + SAMPLE_W'(mag);
                        end
                        default: begin
                            cur = SAMPLE_W'($urandom);
                        end
                    endcase
                end
                fin = noisy ? ($urandom_range(0, 5) == 0) : (j == blk_len - 1);
                send_sample(cur, fin);
                items++;
            end
        end
    endtask

    // result side: check each popped word, then pick the next pop from a
    // random stall pattern
    t_code want;
    int    pop_tick    = 0;
    int    pop_period  = 1;
    int    pop_stalled = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (code_words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word bits %0h len %0d",
                                          o_code_bits, o_code_len));
            end else begin
                want = code_words_due.pop_front();
                compare_field("code_bits", o_code_bits, want.bits);
                compare_field("code_len", o_code_len, want.len);
                compare_field("end_of_stream", o_end_of_stream, want.eos);
                compare_field("last_for_item", o_last_for_item, want.last);
            end
        end
        if (pop_tick % 50 == 0) begin
            pop_period  = $urandom_range(1, 8);
            // at least a quarter of the windows run with no stall at all
            pop_stalled = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, pop_period - 1);
        end
        pop <= ((pop_tick % pop_period) >= pop_stalled);
        pop_tick++;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_sample_blocks();
        test_delta_forms();
        test_runs();
        test_random_blocks();

        // drain everything still owed, then give the block time for strays
        push <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && code_words_due.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (code_words_due.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", code_words_due.size()));
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ delta_rle_sample_encoder.f @@
hdl/drse_pkg.sv
hdl/drse_front.sv
hdl/drse_queue.sv
hdl/drse_back.sv
hdl/delta_rle_sample_encoder.sv
hdl/drse_checker.sv
tb/delta_rle_sample_encoder_test.sv
